[sv/collision_hash_table_defines.svh]
// assertion macros used by the cht_dp rtl file
`ifndef COLLISION_HASH_TABLE_DEFINES_SVH
`define COLLISION_HASH_TABLE_DEFINES_SVH
`ifndef SYNTH
`define CHT_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define CHT_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define CHT_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define CHT_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

[sv/cht_pkg.sv]
`default_nettype none
package cht_pkg;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_MAX_MATCHES = 63;

  localparam int PRIME_W  = 32;
  localparam int OFFSET_W = 64;
  localparam int STATUS_W = 3;

  localparam logic [STATUS_W-1:0] ST_MATCH    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

  typedef struct packed {
    logic                used;
    logic [PRIME_W-1:0]  prime;
    logic [OFFSET_W-1:0] offset;
  } slot_t;

  typedef struct packed {
    logic                load;
    logic                home_start;
    logic                addr_zero;
    logic                addr_home;
    logic                addr_step;
    logic                found_clear;
    logic                found_inc;
    logic                wr_clear;
    logic                wr_entry;
    logic                cnt_clear;
    logic                cnt_inc;
    logic                emit;
    logic [STATUS_W-1:0] emit_code;
  } cmd_t;

  typedef struct packed {
    logic op_clear;
    logic prime_zero;
    logic full;
    logic home_done;
    logic slot_used;
    logic hit;
    logic room;
    logic addr_last;
  } stat_t;

endpackage
`default_nettype wire

[sv/cht_home.sv]
`default_nettype none
module cht_home #(
  parameter int TABLE_DEPTH = cht_pkg::DEF_TABLE_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [cht_pkg::OFFSET_W-1:0]     value,
  output logic                                  done,
  output logic [$clog2(TABLE_DEPTH)-1:0]        home
);
  import cht_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  logic         done_r;
  logic [AW-1:0] home_r;

  assign done = done_r;
  assign home = home_r;

  if (TABLE_DEPTH == (1 << AW)) begin : g_pow2
    // floor modulo by a power of two is the low bits of the two's complement word
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        done_r <= 1'b0;
      end else begin
        done_r <= start;
      end
    end

    always_ff @(posedge clk) begin
      if (start) begin
        home_r <= value[AW-1:0];
      end
    end
  end else begin : g_serial
    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_FOLD = 2'd1;
    localparam logic [1:0] P_SUB  = 2'd2;
    localparam logic [1:0] P_FIX  = 2'd3;
    localparam int HALF_W = OFFSET_W / 2;
    localparam logic [OFFSET_W-1:0] MAXMOD = 64'hFFFF_FFFF_FFFF_FFFF % 64'(TABLE_DEPTH);
    localparam logic [OFFSET_W-1:0] WRAP64 =
      ((MAXMOD + 64'd1) == 64'(TABLE_DEPTH)) ? 64'd0 : (MAXMOD + 64'd1);
    localparam logic [OFFSET_W-1:0] HALF_MOD = 64'h1_0000_0000 % 64'(TABLE_DEPTH);
    localparam logic [OFFSET_W-1:0] HALF_DIV = 64'h1_0000_0000 / 64'(TABLE_DEPTH);
    localparam logic [AW-1:0] WRAP_A  = WRAP64[AW-1:0];
    localparam logic [AW-1:0] DEPTH_A = AW'(TABLE_DEPTH);
    localparam logic [AW:0]   DEPTH_T = (AW + 1)'(TABLE_DEPTH);
    localparam logic [AW-1:0] FOLD_K  = HALF_MOD[AW-1:0];
    localparam logic [HALF_W-1:0] RECIP   = HALF_DIV[HALF_W-1:0];
    localparam logic [HALF_W-1:0] DEPTH_H = HALF_W'(TABLE_DEPTH);

    logic [1:0]           ph_r;
    logic                 sign_r;
    logic [OFFSET_W-1:0]  y_r;
    logic [HALF_W-1:0]    q_r;
    logic [AW:0]          rem_r;
    logic                 hi_zero;
    logic [HALF_W+AW-1:0] fold_prod;
    logic [OFFSET_W-1:0]  fold_nxt;
    logic [OFFSET_W-1:0]  q_prod;
    logic [HALF_W-1:0]    rem_full;
    logic [AW:0]          rem_nxt;
    logic [AW:0]          rem_sub;
    logic [AW-1:0]        red;
    logic [AW-1:0]        fix_nxt;

    // fold the upper half down by 2^32 mod depth until it is empty,
    // then a reciprocal estimate that is at most one low
    always_comb begin
      hi_zero   = (y_r[OFFSET_W-1:HALF_W] == '0);
      fold_prod = {{AW{1'b0}}, y_r[OFFSET_W-1:HALF_W]} * {{HALF_W{1'b0}}, FOLD_K};
      fold_nxt  = {{(HALF_W-AW){1'b0}}, fold_prod} + {{HALF_W{1'b0}}, y_r[HALF_W-1:0]};
      q_prod    = {{HALF_W{1'b0}}, y_r[HALF_W-1:0]} * {{HALF_W{1'b0}}, RECIP};
      rem_full  = y_r[HALF_W-1:0] - (q_r * DEPTH_H);
      rem_nxt   = rem_full[AW:0];
      rem_sub   = rem_r - DEPTH_T;
      red       = (rem_r >= DEPTH_T) ? rem_sub[AW-1:0] : rem_r[AW-1:0];
      // undo the 2^64 weight of the sign bit
      if (!sign_r) begin
        fix_nxt = red;
      end else if (red >= WRAP_A) begin
        fix_nxt = red - WRAP_A;
      end else begin
        fix_nxt = red + (DEPTH_A - WRAP_A);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ph_r   <= P_IDLE;
        done_r <= 1'b0;
      end else begin
        done_r <= (ph_r == P_FIX);
        case (ph_r)
          P_IDLE: begin
            if (start) begin
              ph_r <= P_FOLD;
            end
          end
          P_FOLD: begin
            if (hi_zero) begin
              ph_r <= P_SUB;
            end
          end
          P_SUB: begin
            ph_r <= P_FIX;
          end
          default: begin
            ph_r <= P_IDLE;
          end
        endcase
      end
    end

    always_ff @(posedge clk) begin
      if (start) begin
        y_r    <= value;
        sign_r <= value[OFFSET_W-1];
      end else if ((ph_r == P_FOLD) && !hi_zero) begin
        y_r <= fold_nxt;
      end
      if ((ph_r == P_FOLD) && hi_zero) begin
        q_r <= q_prod[OFFSET_W-1:HALF_W];
      end
      if (ph_r == P_SUB) begin
        rem_r <= rem_nxt;
      end
      if (ph_r == P_FIX) begin
        home_r <= fix_nxt;
      end
    end
  end

endmodule
`default_nettype wire

[sv/cht_ctrl.sv]
`default_nettype none
module cht_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire cht_pkg::stat_t stat,
  output cht_pkg::cmd_t       cmd
);
  import cht_pkg::*;

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_HASH   = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_CLEAR  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        cmd.wr_clear  = 1'b1;
        cmd.addr_step = 1'b1;
        if (stat.addr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.op_clear) begin
          cmd.addr_zero = 1'b1;
          state_nxt     = S_CLEAR;
        end else if (stat.prime_zero) begin
          cmd.emit      = 1'b1;
          cmd.emit_code = ST_ZERO;
          state_nxt     = S_IDLE;
        end else if (stat.full) begin
          cmd.emit      = 1'b1;
          cmd.emit_code = ST_FULL;
          state_nxt     = S_IDLE;
        end else begin
          cmd.home_start = 1'b1;
          state_nxt      = S_HASH;
        end
      end
      S_HASH: begin
        if (stat.home_done) begin
          cmd.addr_home   = 1'b1;
          cmd.found_clear = 1'b1;
          state_nxt       = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!stat.slot_used) begin
          cmd.wr_entry  = 1'b1;
          cmd.cnt_inc   = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_code = ST_INSERTED;
          state_nxt     = S_IDLE;
        end else begin
          cmd.addr_step = 1'b1;
          cmd.found_inc = stat.hit;
          if (stat.hit && stat.room) begin
            cmd.emit      = 1'b1;
            cmd.emit_code = ST_MATCH;
          end
        end
      end
      S_CLEAR: begin
        cmd.wr_clear  = 1'b1;
        cmd.addr_step = 1'b1;
        if (stat.addr_last) begin
          cmd.cnt_clear = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_code = ST_CLEARED;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/cht_dp.sv]
`default_nettype none
`include "collision_hash_table_defines.svh"
module cht_dp #(
  parameter int TABLE_DEPTH = cht_pkg::DEF_TABLE_DEPTH,
  parameter int MAX_MATCHES = cht_pkg::DEF_MAX_MATCHES
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire cht_pkg::cmd_t                       cmd,
  output cht_pkg::stat_t                           stat,
  input  wire logic                                in_operation,
  input  wire logic [cht_pkg::PRIME_W-1:0]         in_prime,
  input  wire logic [cht_pkg::OFFSET_W-1:0]        in_offset,
  output logic                                     out_valid,
  output logic [cht_pkg::STATUS_W-1:0]             out_status,
  output logic [cht_pkg::PRIME_W-1:0]              out_stored_prime,
  output logic [cht_pkg::PRIME_W-1:0]              out_new_prime,
  output logic [cht_pkg::OFFSET_W-1:0]             out_match_offset,
  output logic                                     out_truncated,
  output logic                                     out_last
);
  import cht_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;
  localparam int FW = $clog2(MAX_MATCHES + 2);
  localparam logic [AW-1:0] LAST_A   = AW'(TABLE_DEPTH - 1);
  localparam logic [CW:0]   FULL_LIM = (CW + 1)'(TABLE_DEPTH);
  localparam logic [FW-1:0] MAX_F    = FW'(MAX_MATCHES);

  logic                op_r;
  logic [PRIME_W-1:0]  prime_r;
  logic [OFFSET_W-1:0] offset_r;
  logic [AW-1:0]       addr_r;
  logic [AW-1:0]       addr_nxt;
  logic [CW-1:0]       count_r;
  logic [FW-1:0]       found_r;
  slot_t               mem_r [TABLE_DEPTH];
  slot_t               rd_q_r;
  slot_t               wdata;
  logic                home_done;
  logic [AW-1:0]       home;

  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r;
  logic [PRIME_W-1:0]  stored_prime_r;
  logic [PRIME_W-1:0]  new_prime_r;
  logic [OFFSET_W-1:0] match_offset_r;
  logic                truncated_r;
  logic                last_r;

  cht_home #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_home (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.home_start),
    .value(offset_r),
    .done (home_done),
    .home (home)
  );

  always_comb begin
    if (cmd.addr_zero) begin
      addr_nxt = '0;
    end else if (cmd.addr_home) begin
      addr_nxt = home;
    end else if (cmd.addr_step) begin
      addr_nxt = (addr_r == LAST_A) ? '0 : (addr_r + 1'b1);
    end else begin
      addr_nxt = addr_r;
    end
  end

  always_comb begin
    wdata.used   = cmd.wr_entry;
    wdata.prime  = prime_r;
    wdata.offset = offset_r;
  end

  always_comb begin
    stat.op_clear   = op_r;
    stat.prime_zero = (prime_r == '0);
    stat.full       = ({count_r, 1'b1} >= FULL_LIM);
    stat.home_done  = home_done;
    stat.slot_used  = rd_q_r.used;
    stat.hit        = (rd_q_r.offset == offset_r) && (rd_q_r.prime != prime_r);
    stat.room       = (found_r < MAX_F);
    stat.addr_last  = (addr_r == LAST_A);
  end

  // slot store, read one slot ahead of the probe pointer
  always_ff @(posedge clk) begin
    if (cmd.wr_clear || cmd.wr_entry) begin
      mem_r[addr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_q_r <= mem_r[addr_nxt];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_operation;
      prime_r  <= in_prime;
      offset_r <= in_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r  <= '0;
      count_r <= '0;
      found_r <= '0;
    end else begin
      addr_r <= addr_nxt;
      if (cmd.cnt_clear) begin
        count_r <= '0;
      end else if (cmd.cnt_inc) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.found_clear) begin
        found_r <= '0;
      end else if (cmd.found_inc && (found_r <= MAX_F)) begin
        found_r <= found_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status_r       <= cmd.emit_code;
      stored_prime_r <= (cmd.emit_code == ST_MATCH) ? rd_q_r.prime : '0;
      new_prime_r    <= (cmd.emit_code == ST_CLEARED) ? '0 : prime_r;
      match_offset_r <= (cmd.emit_code == ST_MATCH) ? offset_r : '0;
      truncated_r    <= (cmd.emit_code == ST_INSERTED) && (found_r > MAX_F);
      last_r         <= (cmd.emit_code != ST_MATCH);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_stored_prime = stored_prime_r;
  assign out_new_prime    = new_prime_r;
  assign out_match_offset = match_offset_r;
  assign out_truncated    = truncated_r;
  assign out_last         = last_r;

  `CHT_ASSERT_IMP(a_entry_free, clk, rst_n, cmd.wr_entry, !rd_q_r.used)
  `CHT_ASSERT_IMP(a_entry_room, clk, rst_n, cmd.wr_entry, !stat.full)
  `CHT_ASSERT_NXT(a_count_step, clk, rst_n, cmd.cnt_inc, count_r == $past(count_r) + 1'b1)
  `CHT_ASSERT_IMP(a_only_match_open, clk, rst_n, out_valid_r && !last_r, status_r == ST_MATCH)
  `CHT_ASSERT_IMP(a_match_primes, clk, rst_n, out_valid_r && (status_r == ST_MATCH),
    stored_prime_r != new_prime_r)

endmodule
`default_nettype wire

[sv/collision_hash_table.sv]
`default_nettype none
// Open-addressing hash table with linear probing that reports up to MAX_MATCHES
// stored entries sharing the new entry's offset under a different prime, then
// stores the entry. Results come out strobed by out_valid for a single cycle
// each; the receiver cannot stall, so every word must be taken when shown. Match
// words come one per probe cycle and a word with out_last=1 closes each item: the
// insert word, or the reject or clear word. The probe walks the occupied slots
// from the home slot, one slot read per cycle from the slot memory. With a
// power-of-two TABLE_DEPTH the home slot is the low bits of the offset; with any
// other depth it comes from a remainder unit that folds the offset and finishes
// with a reciprocal multiply. Clearing sweeps the slot memory one slot a cycle,
// and after reset busy stays high while the same sweep empties the table.
module collision_hash_table #(
  parameter int TABLE_DEPTH = cht_pkg::DEF_TABLE_DEPTH,
  parameter int MAX_MATCHES = cht_pkg::DEF_MAX_MATCHES
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 in_operation,
  input  wire logic [cht_pkg::PRIME_W-1:0]          in_prime,
  input  wire logic signed [cht_pkg::OFFSET_W-1:0]  in_offset,
  output logic                                      out_valid,
  output logic [cht_pkg::STATUS_W-1:0]              out_status,
  output logic [cht_pkg::PRIME_W-1:0]               out_stored_prime,
  output logic [cht_pkg::PRIME_W-1:0]               out_new_prime,
  output logic signed [cht_pkg::OFFSET_W-1:0]       out_match_offset,
  output logic                                      out_truncated,
  output logic                                      out_last
);
  import cht_pkg::*;

  cmd_t                cmd;
  stat_t               stat;
  logic [OFFSET_W-1:0] match_offset;

  cht_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .stat (stat),
    .cmd  (cmd)
  );

  cht_dp #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .MAX_MATCHES(MAX_MATCHES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_operation    (in_operation),
    .in_prime        (in_prime),
    .in_offset       (in_offset),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_stored_prime(out_stored_prime),
    .out_new_prime   (out_new_prime),
    .out_match_offset(match_offset),
    .out_truncated   (out_truncated),
    .out_last        (out_last)
  );

  assign out_match_offset = match_offset;

endmodule
`default_nettype wire

[verif/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cht_pkg::*;

  localparam int TABLE_DEPTH = DEF_TABLE_DEPTH;
  localparam int MAX_MATCHES = DEF_MAX_MATCHES;
  localparam longint unsigned DEPTH_U = TABLE_DEPTH;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int QUIET_TAIL = 30;
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 20;
  localparam logic signed [OFFSET_W-1:0] OFF_MIN = {1'b1, {(OFFSET_W-1){1'b0}}};
  localparam logic signed [OFFSET_W-1:0] OFF_MAX = {1'b0, {(OFFSET_W-1){1'b1}}};
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct {
    logic                       operation;
    logic [PRIME_W-1:0]         prime;
    logic signed [OFFSET_W-1:0] offset;
  } table_cmd_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [PRIME_W-1:0]  stored_prime;
    logic [PRIME_W-1:0]  new_prime;
    logic [OFFSET_W-1:0] match_offset;
    logic                truncated;
    logic                last;
  } result_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_operation = 1'b0;
  logic [PRIME_W-1:0] in_prime = '0;
  logic signed [OFFSET_W-1:0] in_offset = '0;
  logic out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [PRIME_W-1:0] out_stored_prime;
  logic [PRIME_W-1:0] out_new_prime;
  logic signed [OFFSET_W-1:0] out_match_offset;
  logic out_truncated;
  logic out_last;

  // table state as the block should hold it
  logic [PRIME_W-1:0]  tbl_prime [TABLE_DEPTH];
  logic [OFFSET_W-1:0] tbl_offset [TABLE_DEPTH];
  bit                  tbl_used [TABLE_DEPTH];
  int unsigned         tbl_count;

  table_cmd_t   pending_cmds [$];
  result_word_t expected_words [$];

  int gap_left = 0;
  int accepted_count = 0;
  int word_count = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int status_seen [5];
  int trunc_seen = 0;

  collision_hash_table #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .MAX_MATCHES(MAX_MATCHES)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_prime        (in_prime),
    .in_offset       (in_offset),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_stored_prime(out_stored_prime),
    .out_new_prime   (out_new_prime),
    .out_match_offset(out_match_offset),
    .out_truncated   (out_truncated),
    .out_last        (out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned home_slot(logic signed [OFFSET_W-1:0] off);
    longint unsigned mag;
    longint unsigned rem;
    mag = off;
    if (!off[OFFSET_W-1]) return int'(mag % DEPTH_U);
    mag = 64'd0 - mag;
    rem = mag % DEPTH_U;
    return (rem == 0) ? 0 : int'(DEPTH_U - rem);
  endfunction

  task automatic push_word(logic [STATUS_W-1:0] status, logic [PRIME_W-1:0] sp,
                           logic [PRIME_W-1:0] np, logic [OFFSET_W-1:0] off,
                           logic trunc, logic last);
    result_word_t w;
    w.status = status;
    w.stored_prime = sp;
    w.new_prime = np;
    w.match_offset = off;
    w.truncated = trunc;
    w.last = last;
    expected_words.push_back(w);
    if (status < 5) status_seen[status]++;
    if (trunc) trunc_seen++;
  endtask

  // updates the table and queues every word the command should produce
  task automatic apply_table_op(table_cmd_t c);
    int unsigned slot;
    int unsigned probes;
    int unsigned hits;
    if (c.operation == OP_CLEAR) begin
      foreach (tbl_used[i]) tbl_used[i] = 1'b0;
      tbl_count = 0;
      push_word(ST_CLEARED, '0, '0, '0, 1'b0, 1'b1);
    end else if (c.prime == '0) begin
      push_word(ST_ZERO, '0, '0, '0, 1'b0, 1'b1);
    end else if (2 * tbl_count + 1 >= TABLE_DEPTH) begin
      push_word(ST_FULL, '0, c.prime, '0, 1'b0, 1'b1);
    end else begin
      slot = home_slot(c.offset);
      hits = 0;
      probes = 0;
      while (probes < TABLE_DEPTH && tbl_used[slot]) begin
        if (tbl_offset[slot] == c.offset && tbl_prime[slot] != c.prime) begin
          if (hits < MAX_MATCHES)
            push_word(ST_MATCH, tbl_prime[slot], c.prime, c.offset, 1'b0, 1'b0);
          hits++;
        end
        slot = (slot + 1) % TABLE_DEPTH;
        probes++;
      end
      if (tbl_used[slot]) begin
        push_word(ST_FULL, '0, c.prime, '0, 1'b0, 1'b1);
      end else begin
        tbl_prime[slot] = c.prime;
        tbl_offset[slot] = c.offset;
        tbl_used[slot] = 1'b1;
        tbl_count = (tbl_count + 1) & 11'h7ff;
        push_word(ST_INSERTED, '0, c.prime, '0, hits > MAX_MATCHES, 1'b1);
      end
    end
  endtask

  task automatic queue_cmd(logic op, logic [PRIME_W-1:0] prime,
                           logic signed [OFFSET_W-1:0] off);
    table_cmd_t c;
    c.operation = op;
    c.prime = prime;
    c.offset = off;
    pending_cmds.push_back(c);
  endtask

  task automatic check_field(string name, logic [OFFSET_W-1:0] want_v,
                             logic [OFFSET_W-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want_v, got_v);
      mismatch_count++;
    end
  endtask

  // driver: one command word per handshake, random idle bursts between some of them
  always @(posedge clk) begin : driver
    bit go;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      go = start;
      if (start && !busy) begin
        apply_table_op(pending_cmds.pop_front());
        accepted_count++;
        go = 1'b0;
        if (pending_cmds.size() > QUIET_TAIL && $urandom_range(0, 2) == 0)
          gap_left = $urandom_range(1, 11);
      end
      if (!go) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() > 0) begin
          go = 1'b1;
          in_operation <= pending_cmds[0].operation;
          in_prime <= pending_cmds[0].prime;
          in_offset <= pending_cmds[0].offset;
        end
      end
      start <= go;
    end
  end

  // monitor: each result word is shown for one cycle, sampled mid-cycle
  always @(negedge clk) begin : monitor
    result_word_t want;
    if (rst_n && out_valid) begin
      word_count++;
      if (expected_words.size() == 0) begin
        $error("result word with none expected: status %0d", out_status);
        mismatch_count++;
      end else begin
        want = expected_words.pop_front();
        check_field("status", OFFSET_W'(want.status), OFFSET_W'(out_status));
        check_field("stored_prime", OFFSET_W'(want.stored_prime),
                    OFFSET_W'(out_stored_prime));
        check_field("new_prime", OFFSET_W'(want.new_prime), OFFSET_W'(out_new_prime));
        check_field("match_offset", want.match_offset, out_match_offset);
        check_field("truncated", OFFSET_W'(want.truncated), OFFSET_W'(out_truncated));
        check_field("last", OFFSET_W'(want.last), OFFSET_W'(out_last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_count, expected_words.size());
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    logic signed [OFFSET_W-1:0] off;
    logic signed [OFFSET_W-1:0] off_pool [6];
    logic [PRIME_W-1:0] prime_pool [4];
    logic [PRIME_W-1:0] base;
    int unsigned home_base;
    int unsigned pick;

    foreach (tbl_used[i]) tbl_used[i] = 1'b0;
    tbl_count = 0;

    // directed: extremes, wraparound, repeats and op priority
    queue_cmd(OP_CLEAR, '0, '0);
    queue_cmd(OP_INSERT, 32'hFFFF_FFFF, OFF_MIN);
    queue_cmd(OP_INSERT, 32'd1, OFF_MIN);
    queue_cmd(OP_INSERT, 32'd1, OFF_MIN);
    queue_cmd(OP_INSERT, '0, -64'sd1);
    queue_cmd(OP_INSERT, 32'd7, -64'sd1);
    queue_cmd(OP_INSERT, 32'd9, 64'sd1023);
    queue_cmd(OP_INSERT, 32'h8000_0000, OFF_MAX);
    queue_cmd(OP_INSERT, 32'd5, -64'sd1);
    queue_cmd(OP_INSERT, 32'd11, -64'sd1024);
    queue_cmd(OP_INSERT, 32'd13, -64'sd1025);
    queue_cmd(OP_INSERT, 32'd17, 64'sd1024);
    queue_cmd(OP_INSERT, '0, OFF_MIN);
    queue_cmd(OP_CLEAR, 32'hFFFF_FFFF, -64'sd1);
    queue_cmd(OP_INSERT, 32'd7, -64'sd1);
    queue_cmd(OP_INSERT, 32'd3, '0);
    queue_cmd(OP_INSERT, 32'd19, '0);
    queue_cmd(OP_CLEAR, '0, OFF_MAX);
    queue_cmd(OP_INSERT, 32'h5555_5555, 64'sh5555_5555_5555_5555);
    queue_cmd(OP_INSERT, 32'hAAAA_AAAA, 64'shAAAA_AAAA_AAAA_AAAA);
    queue_cmd(OP_CLEAR, $urandom, {$urandom, $urandom});

    // one long cluster on a single offset, past the reported match limit
    off = {$urandom, $urandom};
    base = $urandom_range(1, 32'hFFFF_0000);
    for (int i = 0; i < MAX_MATCHES + 3; i++)
      queue_cmd(OP_INSERT, base + i, off);
    queue_cmd(OP_INSERT, base, off);
    queue_cmd(OP_CLEAR, '0, '0);

    // random: mostly inserts on a few colliding offsets and primes
    home_base = $urandom_range(0, TABLE_DEPTH - 1);
    foreach (off_pool[j]) begin
      off_pool[j] = {$urandom, $urandom};
      off_pool[j][9:0] = 10'((home_base + j % 3) % TABLE_DEPTH);
    end
    foreach (prime_pool[j]) prime_pool[j] = $urandom | 32'd1;
    for (int n = 0; n < 21; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        queue_cmd(OP_CLEAR, $urandom, {$urandom, $urandom});
      end else if (pick < 10) begin
        queue_cmd(OP_INSERT, '0, {$urandom, $urandom});
      end else begin
        off = ($urandom_range(0, 9) < 7) ? off_pool[$urandom_range(0, 5)]
                                          : {$urandom, $urandom};
        queue_cmd(OP_INSERT,
                  $urandom_range(0, 1) ? prime_pool[$urandom_range(0, 3)] : $urandom,
                  off);
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || start) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d commands sent, %0d result words checked: %0d matches, %0d inserts",
             accepted_count, word_count, status_seen[ST_MATCH], status_seen[ST_INSERTED]);
    $display("%0d table-full rejects, %0d zero-prime rejects, %0d clears, %0d truncated",
             status_seen[ST_FULL], status_seen[ST_ZERO], status_seen[ST_CLEARED],
             trunc_seen);
    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
